// ===== sv/fbab_pkg.sv =====
// Shared types and constants of the framebuffer alpha blend store.
`default_nettype none

package fbab_pkg;

   localparam int unsigned POS_W       = 12;
   localparam int unsigned CH_W        = 8;
   localparam int unsigned FUNC_W      = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned ADDR_FULL_W = 26;
   localparam int unsigned SUM_W       = 16;
   localparam int unsigned RECIP_W     = 16;
   localparam int unsigned RECIP_SHIFT = 23;

   // ceil(2^23 / 255); exact floor division for sums up to 255 * 255
   localparam logic [RECIP_W-1:0] RECIP_255 = 16'd32897;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BLEND = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FB_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FB_HEIGHT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] FB_DIM_RESET = 13'd256;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

   // Bit layout matches the stored word: red in the low byte, alpha on top
   typedef struct packed {
      logic [CH_W-1:0] alpha;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pixel_type;

endpackage

`default_nettype wire

// ===== sv/fbab_blend.sv =====
// Source-over blend unit: registered channel sums, then exact divide by 255.
`default_nettype none

module fbab_blend (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire fbab_pkg::pixel_type src,
   input  wire fbab_pkg::pixel_type dst,
   output fbab_pkg::pixel_type      mixed
);

   logic [fbab_pkg::CH_W-1:0]  inv_alpha;
   logic [fbab_pkg::SUM_W-1:0] red_sum_ff;
   logic [fbab_pkg::SUM_W-1:0] green_sum_ff;
   logic [fbab_pkg::SUM_W-1:0] blue_sum_ff;

   function automatic logic [fbab_pkg::SUM_W-1:0] mix_sum(
      input logic [fbab_pkg::CH_W-1:0] s,
      input logic [fbab_pkg::CH_W-1:0] d,
      input logic [fbab_pkg::CH_W-1:0] a,
      input logic [fbab_pkg::CH_W-1:0] na
   );
      logic [fbab_pkg::SUM_W-1:0] ps;
      logic [fbab_pkg::SUM_W-1:0] pd;
      ps = {8'd0, s} * {8'd0, a};
      pd = {8'd0, d} * {8'd0, na};
      return ps + pd;
   endfunction

   // floor(v / 255) through the reciprocal; v never exceeds 255 * 255
   function automatic logic [fbab_pkg::CH_W-1:0] div255(
      input logic [fbab_pkg::SUM_W-1:0] v
   );
      logic [fbab_pkg::SUM_W+fbab_pkg::RECIP_W-1:0] p;
      p = {16'd0, v} * {16'd0, fbab_pkg::RECIP_255};
      return p[fbab_pkg::RECIP_SHIFT+fbab_pkg::CH_W-1:fbab_pkg::RECIP_SHIFT];
   endfunction

   assign inv_alpha = fbab_pkg::ALPHA_OPAQUE - src.alpha;

   always_ff @(posedge clock) begin
      if (load) begin
         red_sum_ff   <= mix_sum(src.red,   dst.red,   src.alpha, inv_alpha);
         green_sum_ff <= mix_sum(src.green, dst.green, src.alpha, inv_alpha);
         blue_sum_ff  <= mix_sum(src.blue,  dst.blue,  src.alpha, inv_alpha);
      end
   end

   always_comb begin
      mixed.red   = div255(red_sum_ff);
      mixed.green = div255(green_sum_ff);
      mixed.blue  = div255(blue_sum_ff);
      mixed.alpha = fbab_pkg::ALPHA_OPAQUE;
   end

endmodule

`default_nettype wire

// ===== sv/framebuffer_alpha_blend_store_core.sv =====
// Top level of the framebuffer alpha blend store.
//
// RGBA8888 pixel store of 2^STORE_ADDR_BITS words addressed as
// pos_y * fb_width + pos_x; func selects raw write, read-back or source-over
// blend. After reset a clearing pass writes zero to every word, one per cycle,
// during which req_stall stays high; csr writes are taken at any time. Items
// are handled one at a time by a sequencer around the single-port store with
// a registered read: a raw write, an opaque or transparent blend, an ignored
// item or func 3 pass through accept, address multiply and lookup; a read
// adds the store read (skipped when out of range) and a response step, plus
// any wait for the response register to free up; a partial-alpha blend adds
// read, sum, divide and write back. A response waiting on rsp_stall does not
// hold off the next item until that item itself needs to respond.
`default_nettype none

module framebuffer_alpha_blend_store_core #(
   parameter int unsigned STORE_ADDR_BITS = 16,
   parameter int unsigned COORD_BITS      = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [fbab_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [fbab_pkg::POS_W-1:0]           req_pos_x,
   input  wire logic [fbab_pkg::POS_W-1:0]           req_pos_y,
   input  wire logic [fbab_pkg::CH_W-1:0]            req_src_red,
   input  wire logic [fbab_pkg::CH_W-1:0]            req_src_green,
   input  wire logic [fbab_pkg::CH_W-1:0]            req_src_blue,
   input  wire logic [fbab_pkg::CH_W-1:0]            req_src_alpha,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [fbab_pkg::CH_W-1:0]                 rsp_out_red,
   output logic [fbab_pkg::CH_W-1:0]                 rsp_out_green,
   output logic [fbab_pkg::CH_W-1:0]                 rsp_out_blue,
   output logic [fbab_pkg::CH_W-1:0]                 rsp_out_alpha,
   output logic                                      rsp_out_of_range,

   input  wire logic                                 csr_we,
   input  wire logic [fbab_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fbab_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned PosW      = fbab_pkg::POS_W;
   localparam int unsigned AddrFullW = fbab_pkg::ADDR_FULL_W;
   localparam int unsigned DimW      = fbab_pkg::CSR_DATA_W;
   localparam int unsigned Depth     = 2 ** STORE_ADDR_BITS;

   localparam logic [PosW-1:0] CoordMask =
      (COORD_BITS >= PosW) ? {PosW{1'b1}} : PosW'((1 << COORD_BITS) - 1);
   localparam logic [STORE_ADDR_BITS-1:0] LastAddr = STORE_ADDR_BITS'(Depth - 1);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_ADDR  = 7'b0000100,
      ST_LOOK  = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [DimW-1:0] width_ff;
   logic [DimW-1:0] height_ff;

   // latched item
   logic [fbab_pkg::FUNC_W-1:0] func_ff;
   logic [PosW-1:0]             x_ff;
   logic [PosW-1:0]             y_ff;
   fbab_pkg::pixel_type         src_ff;

   logic [AddrFullW-1:0]        addr_ff;
   logic                        inside_ff;
   logic                        ok_ff;
   logic                        ok;

   logic [STORE_ADDR_BITS-1:0]  clr_addr_ff;

   fbab_pkg::pixel_type         store_mem [Depth];
   fbab_pkg::pixel_type         rd_data_ff;
   logic                        mem_we;
   logic                        mem_re;
   logic [STORE_ADDR_BITS-1:0]  mem_waddr;
   fbab_pkg::pixel_type         mem_wdata;

   fbab_pkg::pixel_type         mixed;
   logic                        blend_load;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_load;
   logic                        rsp_free;
   fbab_pkg::pixel_type         rsp_pixel_ff;
   logic                        rsp_oor_ff;

   logic [PosW-1:0]             x_m;
   logic [PosW-1:0]             y_m;
   logic                        req_xfer;
   logic                        partial_alpha;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign x_m = x_ff & CoordMask;
   assign y_m = y_ff & CoordMask;

   assign ok = inside_ff && ((addr_ff >> STORE_ADDR_BITS) == '0);
   assign partial_alpha = (src_ff.alpha != fbab_pkg::ALPHA_CLEAR) &&
                          (src_ff.alpha != fbab_pkg::ALPHA_OPAQUE);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fbab_pkg::FB_DIM_RESET;
         height_ff <= fbab_pkg::FB_DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fbab_pkg::CSR_FB_WIDTH:  width_ff  <= csr_wdata;
            fbab_pkg::CSR_FB_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = addr_ff[STORE_ADDR_BITS-1:0];
      mem_wdata  = src_ff;
      blend_load = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_IDLE;
            unique case (func_ff)
               fbab_pkg::FUNC_WRITE: begin
                  mem_we = ok;
               end
               fbab_pkg::FUNC_READ: begin
                  mem_re   = ok;
                  state_in = ok ? ST_READ : ST_RESP;
               end
               fbab_pkg::FUNC_BLEND: begin
                  if (ok && src_ff.alpha == fbab_pkg::ALPHA_OPAQUE) begin
                     mem_we = 1'b1;
                  end else if (ok && partial_alpha) begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end
               end
               default: ;
            endcase
         end
         ST_READ: begin
            if (func_ff == fbab_pkg::FUNC_BLEND) begin
               blend_load = 1'b1;
               state_in   = ST_DIV;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            mem_we    = 1'b1;
            mem_wdata = mixed;
            state_in  = ST_IDLE;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // item and address registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff      <= req_func;
         x_ff         <= req_pos_x;
         y_ff         <= req_pos_y;
         src_ff.red   <= req_src_red;
         src_ff.green <= req_src_green;
         src_ff.blue  <= req_src_blue;
         src_ff.alpha <= req_src_alpha;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff   <= AddrFullW'(y_m * width_ff) + AddrFullW'(x_m);
         inside_ff <= (DimW'(x_m) < width_ff) && (DimW'(y_m) < height_ff);
      end
      if (state_ff == ST_LOOK) begin
         ok_ff <= ok;
      end
   end

   // pixel store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[addr_ff[STORE_ADDR_BITS-1:0]];
      end
   end

   fbab_blend u_blend (
      .clock (clock),
      .load  (blend_load),
      .src   (src_ff),
      .dst   (rd_data_ff),
      .mixed (mixed)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= ok_ff ? rd_data_ff : '0;
         rsp_oor_ff   <= !ok_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_pixel_ff.red;
   assign rsp_out_green    = rsp_pixel_ff.green;
   assign rsp_out_blue     = rsp_pixel_ff.blue;
   assign rsp_out_alpha    = rsp_pixel_ff.alpha;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire
